// ----- hw/rtl/pop_stat_pkg.sv -----
package pop_stat_pkg;

  localparam int unsigned SCORE_W   = 32;
  localparam int unsigned VAR_W     = 48;
  localparam int unsigned CNT_OUT_W = 11;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic                      kind;
    logic signed [SCORE_W-1:0] score;
  } in_item_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] min_score;
    logic signed [SCORE_W-1:0] max_score;
    logic signed [SCORE_W-1:0] mean_score;
    logic [VAR_W-1:0]          variance_out;
    logic [CNT_OUT_W-1:0]      sample_count;
    logic                      dropped;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_PASS_GO,
    ST_PASS_WAIT,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_DONE
  } pop_state_e;

endpackage

// ----- hw/rtl/pop_stat_div.sv -----
module pop_stat_div #(
  parameter int unsigned DW = 74,
  parameter int unsigned CW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [CW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);
  import pop_stat_pkg::*;

  localparam int unsigned IW = $clog2(DW + 1);

  logic [DW-1:0] quo_q;
  logic [CW-1:0] rem_q;
  logic [CW-1:0] div_q;
  logic [IW-1:0] iter_q;
  logic          busy_q;
  logic          done_q;

  logic [CW:0]   trial;
  logic [CW:0]   diff;
  logic          ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= busy_q && (iter_q == IW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= IW'(DW);
      end else if (busy_q) begin
        iter_q <= iter_q - IW'(1);
        if (iter_q == IW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");
`endif

endmodule

// ----- hw/rtl/pop_stat_sqacc.sv -----
module pop_stat_sqacc #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       wr_en_i,
  input  logic [$clog2(MAX_SAMPLES)-1:0]             wr_addr_i,
  input  logic [pop_stat_pkg::SCORE_W-1:0]           wr_data_i,
  input  logic                                       start_i,
  input  logic [$clog2(MAX_SAMPLES+1)-1:0]           count_i,
  input  logic signed [pop_stat_pkg::SCORE_W-1:0]    mean_i,
  output logic                                       done_o,
  output logic [2*pop_stat_pkg::SCORE_W+$clog2(MAX_SAMPLES)-1:0] sumsq_o
);
  import pop_stat_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_SAMPLES);
  localparam int unsigned CW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SQW = 2 * SCORE_W + AW;

  logic [SCORE_W-1:0]   mem [MAX_SAMPLES];
  logic [SCORE_W-1:0]   rd_q;
  logic [CW-1:0]        idx_q;
  logic                 run_q;
  logic                 rv_q;
  logic                 sv_q;
  logic                 busy_q;
  logic [2*SCORE_W-1:0] sq_q;
  logic [SQW-1:0]       acc_q;

  logic signed [SCORE_W:0] dif;
  logic [SCORE_W-1:0]      mag;
  logic [2*SCORE_W-1:0]    prod;
  logic [CW-1:0]           idx_nx;

  // read -> square -> accumulate, one entry per cycle
  assign dif    = {mean_i[SCORE_W-1], mean_i} - {rd_q[SCORE_W-1], rd_q};
  assign mag    = dif[SCORE_W] ? SCORE_W'(-dif) : dif[SCORE_W-1:0];
  assign prod   = mag * mag;
  assign idx_nx = idx_q + CW'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (run_q) begin
      rd_q <= mem[idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      run_q  <= 1'b0;
      rv_q   <= 1'b0;
      sv_q   <= 1'b0;
      busy_q <= 1'b0;
    end else begin
      rv_q <= run_q;
      sv_q <= rv_q;
      if (start_i) begin
        idx_q  <= '0;
        run_q  <= 1'b1;
        busy_q <= 1'b1;
      end else begin
        if (run_q) begin
          idx_q <= idx_nx;
          if (idx_nx == count_i) begin
            run_q <= 1'b0;
          end
        end
        if (done_o) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rv_q) begin
      sq_q <= prod;
    end
    if (start_i) begin
      acc_q <= '0;
    end else if (sv_q) begin
      acc_q <= acc_q + SQW'(sq_q);
    end
  end

  assign done_o  = busy_q && !run_q && !rv_q && !sv_q;
  assign sumsq_o = acc_q;

`ifndef NO_ASSERTIONS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> (idx_q < count_i))
    else $error("store read beyond filled entries");
`endif

endmodule

// ----- hw/rtl/population_statistics_unit.sv -----
// Channel | Direction | Handshake                 | Item
// in      | input     | in_valid_i / in_stall_o   | in_item_i  (kind, score)
// out     | output    | out_valid_o / out_stall_i | out_item_o (min..dropped)
//
// A clear item is taken without holding in_stall_o high and gives no result.
// An add holds in_stall_o high through a bit-serial mean divide, a sweep of the store,
// a bit-serial variance divide (DW = divider width, 58 at defaults) and the load of
// the output register, which waits while the output is stalled.
// The output register lets the next item start while a result waits.
// Reset is asynchronous, active low; it empties the statistics but not the store.
module population_statistics_unit #(
  parameter int unsigned MAX_SAMPLES   = 1024,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  pop_stat_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output pop_stat_pkg::out_item_t out_item_o
);
  import pop_stat_pkg::*;

  localparam int unsigned LG  = $clog2(MAX_SAMPLES);
  localparam int unsigned CW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SW  = SCORE_W + LG;        // running sum
  localparam int unsigned SQW = 2 * SCORE_W + LG;    // sum of squares
  localparam int unsigned DW  = SQW - FRACTION_BITS; // divider dividend

  pop_state_e state_q, state_d;

  // generation statistics
  logic [CW-1:0]              cnt_q;
  logic signed [SCORE_W-1:0]  min_q;
  logic signed [SCORE_W-1:0]  max_q;
  logic signed [SW-1:0]       sum_q;

  // per-item results
  logic signed [SCORE_W-1:0]  mean_q;
  logic [VAR_W-1:0]           var_q;
  logic                       drop_q;

  logic                       out_valid_q;
  out_item_t                  out_q;

  logic                       in_acc;
  logic                       full;
  logic signed [SW-1:0]       score_x;
  logic [SW-1:0]              sum_abs;

  // sequencer controls
  logic                       div_start;
  logic                       div_sel_var;
  logic                       acc_start;
  logic                       out_load;

  logic [DW-1:0]              div_dividend;
  logic                       div_done;
  logic [DW-1:0]              div_quo;
  logic [SCORE_W-1:0]         mean_mag;
  logic [DW+VAR_W-1:0]        quo_x;
  logic [VAR_W-1:0]           var_sat;
  logic [CW+CNT_OUT_W-1:0]    cnt_x;

  logic                       acc_done;
  logic [SQW-1:0]             sumsq;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign full    = (cnt_q == CW'(MAX_SAMPLES));
  assign score_x = {{LG{in_item_i.score[SCORE_W-1]}}, in_item_i.score};
  assign sum_abs = sum_q[SW-1] ? SW'(-sum_q) : sum_q;

  // mean: |sum| / count; variance: (sumsq >> FRACTION_BITS) / count
  assign div_dividend = div_sel_var ? sumsq[SQW-1:FRACTION_BITS]
                                    : {{(DW-SW){1'b0}}, sum_abs};
  assign mean_mag = div_quo[SCORE_W-1:0];

  // saturate the variance quotient at the field limit
  assign quo_x   = {{VAR_W{1'b0}}, div_quo};
  assign var_sat = (|quo_x[DW+VAR_W-1:VAR_W]) ? {VAR_W{1'b1}} : quo_x[VAR_W-1:0];

  assign cnt_x = {{CNT_OUT_W{1'b0}}, cnt_q};

  pop_stat_div #(
    .DW(DW),
    .CW(CW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (cnt_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  pop_stat_sqacc #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_sqacc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (in_acc && (in_item_i.kind == KIND_ADD) && !full),
    .wr_addr_i(cnt_q[LG-1:0]),
    .wr_data_i(in_item_i.score),
    .start_i  (acc_start),
    .count_i  (cnt_q),
    .mean_i   (mean_q),
    .done_o   (acc_done),
    .sumsq_o  (sumsq)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_item_i.kind == KIND_ADD)) begin
          state_d = ST_MEAN_GO;
        end
      end
      ST_MEAN_GO:   state_d = ST_MEAN_WAIT;
      ST_MEAN_WAIT: if (div_done) state_d = ST_PASS_GO;
      ST_PASS_GO:   state_d = ST_PASS_WAIT;
      ST_PASS_WAIT: if (acc_done) state_d = ST_VAR_GO;
      ST_VAR_GO:    state_d = ST_VAR_WAIT;
      ST_VAR_WAIT:  if (div_done) state_d = ST_DONE;
      ST_DONE:      if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o  = 1'b1;
    div_start   = 1'b0;
    div_sel_var = 1'b0;
    acc_start   = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      ST_IDLE:      in_stall_o = 1'b0;
      ST_MEAN_GO:   div_start = 1'b1;
      ST_MEAN_WAIT: ;
      ST_PASS_GO:   acc_start = 1'b1;
      ST_PASS_WAIT: div_sel_var = 1'b1;
      ST_VAR_GO: begin
        div_start   = 1'b1;
        div_sel_var = 1'b1;
      end
      ST_VAR_WAIT:  div_sel_var = 1'b1;
      ST_DONE:      out_load = !out_valid_q || !out_stall_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      min_q       <= '0;
      max_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        if (in_item_i.kind == KIND_CLEAR) begin
          cnt_q <= '0;
          min_q <= '0;
          max_q <= '0;
          sum_q <= '0;
        end else if (!full) begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == '0) begin
            // first score of the generation
            min_q <= in_item_i.score;
            max_q <= in_item_i.score;
            sum_q <= score_x;
          end else begin
            if (in_item_i.score < min_q) min_q <= in_item_i.score;
            if (in_item_i.score > max_q) max_q <= in_item_i.score;
            sum_q <= sum_q + score_x;
          end
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_item_i.kind == KIND_ADD)) begin
      drop_q <= full;
    end
    if ((state_q == ST_MEAN_WAIT) && div_done) begin
      mean_q <= sum_q[SW-1] ? SCORE_W'(-mean_mag) : mean_mag;
    end
    if ((state_q == ST_VAR_WAIT) && div_done) begin
      var_q <= var_sat;
    end
    if (out_load) begin
      out_q.min_score    <= min_q;
      out_q.max_score    <= max_q;
      out_q.mean_score   <= mean_q;
      out_q.variance_out <= var_q;
      out_q.sample_count <= cnt_x[CNT_OUT_W-1:0];
      out_q.dropped      <= drop_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef NO_ASSERTIONS
  a_add_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_item_i.kind == KIND_ADD)) |=> in_stall_o)
    else $error("add item did not hold off input");

  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_SAMPLES))
    else $error("stored count past store depth");

  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (min_q <= max_q))
    else $error("running min above running max");
`endif

endmodule

// ----- test/tb_population_statistics_unit.sv -----
module tb_population_statistics_unit;
  import pop_stat_pkg::*;

  // Predictor sizing, matching the defaults the block is built with.
  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned FRAC_BITS   = 16;
  localparam logic [VAR_W-1:0] VAR_MAX = '1;

  // The drain wait covers one longest add (full store); the watchdog covers
  // many of those plus the longest sender gap and receiver stall.
  localparam int unsigned DRAIN_CYCLES = 1500;
  localparam int unsigned QUIET_LIMIT  = 20000;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  population_statistics_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Generation predictor: own copy of the score store and running stats.
  // ---------------------------------------------------------------------
  logic signed [SCORE_W-1:0] gen_scores [STORE_DEPTH];
  int unsigned gen_count = 0;
  longint      gen_min   = 0;
  longint      gen_max   = 0;
  longint      gen_sum   = 0;

  in_item_t  score_items_q [$];     // items waiting to be driven
  out_item_t expected_stats_q [$];  // predicted results, oldest first

  int unsigned adds_seen    = 0;
  int unsigned clears_seen  = 0;
  int unsigned drops_seen   = 0;
  int unsigned peak_count   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;

  // Variance from the exact sum of squared distances to the mean; 128 bits is plenty since
  // 1024 terms of < 2^64 stay below 2^74.
  function automatic logic [VAR_W-1:0] variance_about(input longint mean);
    logic [127:0] sq_sum;
    logic [127:0] quot;
    logic [63:0]  mag;
    longint       diff;
    sq_sum = '0;
    for (int i = 0; i < gen_count; i++) begin
      diff   = mean - longint'(gen_scores[i]);
      mag    = (diff < 0) ? 64'(-diff) : 64'(diff);
      sq_sum = sq_sum + ({64'd0, mag} * {64'd0, mag});
    end
    quot = (sq_sum >> FRAC_BITS) / gen_count;
    return (quot > VAR_MAX) ? VAR_MAX : quot[VAR_W-1:0];
  endfunction

  task automatic predict_stats(input in_item_t item);
    out_item_t stats;
    longint    score;
    longint    mean;
    stats = '0;
    if (item.kind == KIND_CLEAR) begin
      // Clear empties the generation and gives no result.
      gen_count = 0;
      gen_min   = 0;
      gen_max   = 0;
      gen_sum   = 0;
      clears_seen++;
      return;
    end
    adds_seen++;
    score = $signed(item.score);
    if (gen_count < STORE_DEPTH) begin
      gen_scores[gen_count] = item.score;
      if (gen_count == 0) begin
        // First score of a generation seeds min and max.
        gen_min = score;
        gen_max = score;
        gen_sum = score;
      end else begin
        if (score < gen_min) gen_min = score;
        if (score > gen_max) gen_max = score;
        gen_sum += score;
      end
      gen_count++;
      if (gen_count > peak_count) peak_count = gen_count;
    end else begin
      // Full store: score dropped, stats of what is stored still reported.
      stats.dropped = 1'b1;
      drops_seen++;
    end
    mean = gen_sum / longint'(gen_count);  // truncates toward zero
    stats.min_score    = 32'(gen_min);
    stats.max_score    = 32'(gen_max);
    stats.mean_score   = 32'(mean);
    stats.variance_out = variance_about(mean);
    stats.sample_count = CNT_OUT_W'(gen_count);
    expected_stats_q.insert(expected_stats_q.size(), stats);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------
  int score_center = 0;

  task automatic queue_item(input logic kind, input logic signed [SCORE_W-1:0] score);
    in_item_t item;
    item.kind  = kind;
    item.score = score;
    score_items_q.insert(score_items_q.size(), item);
  endtask

  // Mix of extremes, full-range noise, tight clusters around a per-generation
  // center (small variance) and moderate Q16.16 values.
  function automatic logic signed [SCORE_W-1:0] pick_score();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3:    return $urandom;
      4, 5, 6: return score_center + int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      default: return int'($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
    endcase
  endfunction

  initial begin : stimulus
    int unsigned random_items;
    int unsigned gen_len;
    random_items = 0;

    // Directed: first score after reset, extremes, clear handling.
    queue_item(KIND_ADD,   32'sh0000_0000);
    queue_item(KIND_ADD,   32'sh7FFF_FFFF);
    queue_item(KIND_ADD,   32'sh8000_0000);
    queue_item(KIND_ADD,   32'shFFFF_FFFF);
    queue_item(KIND_ADD,   32'sh0001_0000);
    queue_item(KIND_CLEAR, 32'sh5A5A_A5A5);  // score is don't-care on clear
    queue_item(KIND_ADD,  -32'sh1234_5678);  // first score after a clear
    queue_item(KIND_CLEAR, 32'sh0000_0000);
    queue_item(KIND_CLEAR, 32'shFFFF_FFFF);  // clear of an empty generation
    queue_item(KIND_ADD,   32'sh7FFF_FFFF);
    queue_item(KIND_ADD,   32'sh7FFF_FFFF);  // identical scores, zero variance
    queue_item(KIND_CLEAR, 32'sh8000_0000);
    queue_item(KIND_ADD,   32'sh8000_0000);  // widest spread, mean rounds to 0
    queue_item(KIND_ADD,   32'sh7FFF_FFFF);
    queue_item(KIND_ADD,   32'sh5555_5555);
    queue_item(KIND_ADD,   32'shAAAA_AAAA);
    queue_item(KIND_ADD,  -32'sh0000_0001);
    queue_item(KIND_CLEAR, 32'sh7FFF_FFFF);
    queue_item(KIND_ADD,  -32'sh0000_0003);  // negative mean
    queue_item(KIND_ADD,   32'sh0000_0001);
    queue_item(KIND_CLEAR, 32'sh0000_0000);

    // Random generations: mostly short ones, some longer, with the odd
    // clear dropped in mid-generation.
    while (random_items < 520) begin
      score_center = int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
      gen_len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (int i = 0; i < gen_len; i++) begin
        if ($urandom_range(0, 19) == 0) queue_item(KIND_CLEAR, $urandom);
        else                            queue_item(KIND_ADD, pick_score());
        random_items++;
      end
      // Most generations end in a clear; the rest keep accumulating.
      if ($urandom_range(0, 3) != 0) begin
        queue_item(KIND_CLEAR, $urandom);
        random_items++;
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (score_items_q.size() != 0 || expected_stats_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d adds (%0d dropped on a full store) and %0d clears, %0d results checked",
             adds_seen, drops_seen, clears_seen, results_seen);
    $display("Largest generation held %0d scores; %0d field mismatches", peak_count, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps. Gap lengths
  // vary widely, down to none, so they land on every phase of an add's
  // divide and sweep. A stalled item is held unchanged.
  // ---------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  logic        next_valid;
  in_item_t    next_item;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_stats(score_items_q.pop_front());
      end
      if (!(in_valid_i && in_stall_o)) begin
        next_valid = 1'b0;
        next_item  = in_item_i;
        if (gap_left != 0) begin
          gap_left--;
        end else if (score_items_q.size() != 0) begin
          next_valid = 1'b1;
          next_item  = score_items_q[0];
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 3))
              0:       gap_left = 0;
              1:       gap_left = $urandom_range(40, 400);
              default: gap_left = $urandom_range(1, 8);
            endcase
          end else begin
            burst_left--;
          end
        end
        in_valid_i <= next_valid;
        in_item_i  <= next_item;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor and receiver stall pattern
  // ---------------------------------------------------------------------
  int unsigned stall_run = 0;
  int unsigned free_run  = 0;
  logic        next_stall;
  out_item_t   want_stats;

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("ERROR result %0d %s: got %0h, expected %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_run = 0;
      free_run  = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_stats_q.size() == 0) begin
          flag_mismatch("unexpected result, sample_count",
                        64'(out_item_o.sample_count), 64'd0);
        end else begin
          want_stats = expected_stats_q.pop_front();
          if (out_item_o.min_score !== want_stats.min_score)
            flag_mismatch("min_score", 64'(out_item_o.min_score),
                          64'(want_stats.min_score));
          if (out_item_o.max_score !== want_stats.max_score)
            flag_mismatch("max_score", 64'(out_item_o.max_score),
                          64'(want_stats.max_score));
          if (out_item_o.mean_score !== want_stats.mean_score)
            flag_mismatch("mean_score", 64'(out_item_o.mean_score),
                          64'(want_stats.mean_score));
          if (out_item_o.variance_out !== want_stats.variance_out)
            flag_mismatch("variance_out", 64'(out_item_o.variance_out),
                          64'(want_stats.variance_out));
          if (out_item_o.sample_count !== want_stats.sample_count)
            flag_mismatch("sample_count", 64'(out_item_o.sample_count),
                          64'(want_stats.sample_count));
          if (out_item_o.dropped !== want_stats.dropped)
            flag_mismatch("dropped", 64'(out_item_o.dropped), 64'(want_stats.dropped));
        end
        results_seen++;
      end

      // Stall runs of mixed length: long free stretches, short choppy
      // stalls, and long stalls that back results up into the block.
      next_stall = 1'b0;
      if (stall_run != 0) begin
        next_stall = 1'b1;
        stall_run--;
      end else if (free_run != 0) begin
        free_run--;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            free_run  = $urandom_range(50, 300);
            stall_run = 0;
          end
          1: begin
            free_run  = $urandom_range(0, 3);
            stall_run = $urandom_range(1, 3);
          end
          2: begin
            free_run  = $urandom_range(0, 20);
            stall_run = $urandom_range(20, 300);
          end
          default: begin
            free_run  = $urandom_range(0, 10);
            stall_run = $urandom_range(1, 12);
          end
        endcase
      end
      out_stall_i <= next_stall;
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: too long without any handshake on either side means a hang.
  // ---------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles, %0d items pending, %0d results outstanding",
               quiet_cycles, score_items_q.size(), expected_stats_q.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- files.f -----
hw/rtl/pop_stat_pkg.sv
hw/rtl/pop_stat_div.sv
hw/rtl/pop_stat_sqacc.sv
hw/rtl/population_statistics_unit.sv
test/tb_population_statistics_unit.sv
